// File: rtl/v3alu_pkg.sv
// Shared types and constants for the three-component vector ALU.
// No dependencies; imported by vec3_alu_core, its checker and the testbench.
`default_nettype none

package v3alu_pkg;

    localparam int WORD_W        = 32;
    localparam int CMD_W         = 4;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 4'd0,
        CMD_SUB    = 4'd1,
        CMD_SCALE  = 4'd2,
        CMD_DOT    = 4'd3,
        CMD_CROSS  = 4'd4,
        CMD_SQLEN  = 4'd5,
        CMD_LENGTH = 4'd6,
        CMD_NORM   = 4'd7,
        CMD_UNIT   = 4'd8
    } t_cmd;

    typedef struct packed {
        logic        [CMD_W-1:0]  cmd;
        logic signed [WORD_W-1:0] a_x;
        logic signed [WORD_W-1:0] a_y;
        logic signed [WORD_W-1:0] a_z;
        logic signed [WORD_W-1:0] b_x;
        logic signed [WORD_W-1:0] b_y;
        logic signed [WORD_W-1:0] b_z;
        logic signed [WORD_W-1:0] scale;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] r_x;
        logic signed [WORD_W-1:0] r_y;
        logic signed [WORD_W-1:0] r_z;
        logic signed [WORD_W-1:0] r_scalar;
        logic                     zero_length;
        logic                     saturated;
    } t_out;

endpackage

`default_nettype wire

// File: rtl/vec3_alu_core.sv
// Fixed point, Q16.16 by default. Throughput: one item per cycle unless the output
// buffer is full; one global enable advances every stage, and a two-entry output
// buffer keeps taking results while the consumer stalls.
// The square root (32 stages, one root bit each) and the divider (FRAC_BITS+2
// stages, one quotient bit each) set the depth.
// Reset (synchronous, active low) clears all valid bits and empties the output buffer.
`default_nettype none

module vec3_alu_core #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  v3alu_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output v3alu_pkg::t_out  o_out_data
);
    import v3alu_pkg::*;

    localparam int W   = WORD_W;
    localparam int PW  = 2 * W;          // product
    localparam int CW  = PW + 1;         // difference of two products
    localparam int SW  = CW + 2;         // sum of three
    localparam int XW  = SW + 1;         // saturation input width
    localparam int RT  = W;              // root bits
    localparam int SQ  = 2 * RT;         // radicand
    localparam int TW  = SQ + 1;         // root trial value
    localparam int LW  = RT + 1;         // rounded length
    localparam int QB  = FRAC_BITS + 2;  // quotient bits
    localparam int NW  = W + FRAC_BITS + 1;
    localparam int DW  = LW + QB;
    localparam int NF  = 6;              // front stages
    localparam int NS  = NF + RT + 2 + QB;

    localparam logic signed [XW-1:0] HALF = XW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [XW-1:0] SMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0] vec;
        logic [W-1:0]      sc;
        logic              clip;
    } t_res;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        t_res              res;
        logic [2:0][W-1:0] mag;
        logic [2:0]        neg;
        logic              zero;
        logic [SQ-1:0]     rem;
        logic [RT-1:0]     root;
    } t_sq;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        t_res               res;
        logic [2:0]         neg;
        logic               zero;
        logic [LW-1:0]      len;
        logic [2:0][NW-1:0] rem;
        logic [2:0][QB-1:0] quo;
    } t_dv;

    // saturate to a word; top bit flags a clip
    function automatic logic [W:0] sat_fn(input logic signed [XW-1:0] v);
        logic [W:0] r;
        if (v > SMAX) begin
            r = {1'b1, SMAX[W-1:0]};
        end else if (v < SMIN) begin
            r = {1'b1, SMIN[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- control
    logic          en;
    logic          push;
    logic          pop;
    logic          wr_head;
    logic [NS-1:0] r_vld;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    t_out          r_q0;
    t_out          r_q1;
    t_out          n_out;

    // Stall everything only when the output buffer is full.
    assign en          = (r_cnt != 2'd2);
    assign o_in_ready  = en;
    assign push        = en && r_vld[NS-1];
    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_q0;
    // the new result lands in the head slot when nothing stays ahead of it
    assign wr_head     = push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= 2'd0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NS-2:0], i_in_valid};
            end
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Shift the buffer on a pop; write the new result behind what stays.
    always_ff @(posedge i_clk) begin
        if (wr_head) begin
            r_q0 <= n_out;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
        if (push && !wr_head) begin
            r_q1 <= n_out;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Six multipliers. Cross and unit use all six; other commands use the even ones
    // and zero the odd ones, so stage 2 can always take a difference.
    logic signed [2:0][W-1:0] va;
    logic signed [2:0][W-1:0] vb;
    logic signed [5:0][W-1:0] ml;
    logic signed [5:0][W-1:0] mr;
    logic signed [2:0][W-1:0] n1_as;
    logic                     n1_asclip;

    logic [CMD_W-1:0]         r1_cmd;
    logic signed [2:0][W-1:0] r1_a;
    logic signed [5:0][PW-1:0] r1_m;
    logic signed [2:0][W-1:0] r1_as;
    logic                     r1_asclip;

    assign va = {i_in_data.a_z, i_in_data.a_y, i_in_data.a_x};
    assign vb = {i_in_data.b_z, i_in_data.b_y, i_in_data.b_x};

    always_comb begin
        logic [W:0]              sr;
        logic signed [XW-1:0]    sum;
        ml = '0;
        mr = '0;
        case (i_in_data.cmd) inside
            CMD_CROSS, CMD_UNIT: begin
                ml[0] = va[1]; mr[0] = vb[2];
                ml[1] = vb[1]; mr[1] = va[2];
                ml[2] = va[2]; mr[2] = vb[0];
                ml[3] = vb[2]; mr[3] = va[0];
                ml[4] = va[0]; mr[4] = vb[1];
                ml[5] = vb[0]; mr[5] = va[1];
            end
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    ml[2*i] = va[i]; mr[2*i] = i_in_data.scale;
                end
            end
            CMD_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    ml[2*i] = va[i]; mr[2*i] = vb[i];
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    ml[2*i] = va[i]; mr[2*i] = va[i];
                end
            end
        endcase
        n1_asclip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (i_in_data.cmd == CMD_SUB) begin
                sum = XW'($signed(va[i])) - XW'($signed(vb[i]));
            end else begin
                sum = XW'($signed(va[i])) + XW'($signed(vb[i]));
            end
            sr        = sat_fn(sum);
            n1_as[i]  = sr[W-1:0];
            n1_asclip = n1_asclip | sr[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd    <= i_in_data.cmd;
            r1_a      <= va;
            r1_as     <= n1_as;
            r1_asclip <= n1_asclip;
            for (int i = 0; i < 6; i++) begin
                r1_m[i] <= PW'($signed(ml[i])) * PW'($signed(mr[i]));
            end
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic [CMD_W-1:0]          r2_cmd;
    logic signed [2:0][W-1:0]  r2_a;
    logic signed [2:0][CW-1:0] r2_c;
    t_res                      r2_res;
    t_res                      n2_res;

    always_comb begin
        n2_res = '0;
        if (r1_cmd == CMD_ADD || r1_cmd == CMD_SUB) begin
            n2_res.vec  = r1_as;
            n2_res.clip = r1_asclip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd <= r1_cmd;
            r2_a   <= r1_a;
            r2_res <= n2_res;
            for (int i = 0; i < 3; i++) begin
                r2_c[i] <= CW'($signed(r1_m[2*i])) - CW'($signed(r1_m[2*i+1]));
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Round each component half up, saturate; add the three for dot/sqlen.
    logic [CMD_W-1:0]         r3_cmd;
    logic signed [2:0][W-1:0] r3_a;
    logic signed [2:0][W-1:0] r3_v;
    logic                     r3_vclip;
    logic signed [SW-1:0]     r3_sum;
    t_res                     r3_res;
    logic signed [2:0][W-1:0] n3_v;
    logic                     n3_vclip;

    always_comb begin
        logic signed [XW-1:0] t;
        logic [W:0]           sr;
        n3_vclip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t        = (XW'($signed(r2_c[i])) + HALF) >>> FRAC_BITS;
            sr       = sat_fn(t);
            n3_v[i]  = sr[W-1:0];
            n3_vclip = n3_vclip | sr[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cmd   <= r2_cmd;
            r3_a     <= r2_a;
            r3_res   <= r2_res;
            r3_v     <= n3_v;
            r3_vclip <= n3_vclip;
            r3_sum   <= SW'($signed(r2_c[0])) + SW'($signed(r2_c[1]))
                      + SW'($signed(r2_c[2]));
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Finish the plain commands; pick the vector to normalize and take |u|.
    logic [CMD_W-1:0]  r4_cmd;
    t_res              r4_res;
    logic [2:0][W-1:0] r4_mag;
    logic [2:0]        r4_neg;
    t_res              n4_res;
    logic [2:0][W-1:0] n4_mag;
    logic [2:0]        n4_neg;

    always_comb begin
        logic signed [XW-1:0]    t;
        logic [W:0]              sr;
        logic signed [2:0][W-1:0] u;
        n4_res = r3_res;
        t      = (XW'(r3_sum) + HALF) >>> FRAC_BITS;
        sr     = sat_fn(t);
        case (r3_cmd) inside
            CMD_SCALE, CMD_CROSS: begin
                n4_res.vec  = r3_v;
                n4_res.clip = r3_vclip;
            end
            CMD_DOT, CMD_SQLEN: begin
                n4_res.sc   = sr[W-1:0];
                n4_res.clip = sr[W];
            end
            CMD_UNIT: begin
                n4_res.clip = r3_vclip;
            end
            default: begin
                n4_res = r3_res;
            end
        endcase
        u = (r3_cmd == CMD_UNIT) ? r3_v : r3_a;
        for (int i = 0; i < 3; i++) begin
            n4_neg[i] = u[i][W-1];
            n4_mag[i] = u[i][W-1] ? (~u[i] + W'(1)) : u[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cmd <= r3_cmd;
            r4_res <= n4_res;
            r4_mag <= n4_mag;
            r4_neg <= n4_neg;
        end
    end

    // ---------------------------------------------------------------- stage 5/6
    logic [CMD_W-1:0]   r5_cmd;
    t_res               r5_res;
    logic [2:0][W-1:0]  r5_mag;
    logic [2:0]         r5_neg;
    logic [2:0][SQ-1:0] r5_sq;

    logic [CMD_W-1:0]   r6_cmd;
    t_res               r6_res;
    logic [2:0][W-1:0]  r6_mag;
    logic [2:0]         r6_neg;
    logic [SQ-1:0]      r6_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_cmd <= r4_cmd;
            r5_res <= r4_res;
            r5_mag <= r4_mag;
            r5_neg <= r4_neg;
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= SQ'(r4_mag[i]) * SQ'(r4_mag[i]);
            end
            r6_cmd <= r5_cmd;
            r6_res <= r5_res;
            r6_mag <= r5_mag;
            r6_neg <= r5_neg;
            r6_s   <= r5_sq[0] + r5_sq[1] + r5_sq[2];
        end
    end

    // ---------------------------------------------------------------- square root
    // One root bit per stage, most significant first.
    t_sq r_sq [RT];
    t_sq sq_head;

    always_comb begin
        sq_head      = '0;
        sq_head.cmd  = r6_cmd;
        sq_head.res  = r6_res;
        sq_head.mag  = r6_mag;
        sq_head.neg  = r6_neg;
        sq_head.zero = (r6_s == '0);
        sq_head.rem  = r6_s;
    end

    for (genvar j = 0; j < RT; j++) begin : g_sqrt
        localparam int K = RT - 1 - j;
        t_sq           s_in;
        t_sq           s_nx;
        logic [TW-1:0] trial;

        if (j == 0) begin : g_first
            assign s_in = sq_head;
        end else begin : g_next
            assign s_in = r_sq[j-1];
        end

        always_comb begin
            trial = (TW'(s_in.root) << (K + 1)) | (TW'(1) << (2 * K));
            s_nx  = s_in;
            if (TW'(s_in.rem) >= trial) begin
                s_nx.rem     = SQ'(TW'(s_in.rem) - trial);
                s_nx.root[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[j] <= s_nx;
            end
        end
    end

    // ---------------------------------------------------------------- round, prep
    t_dv r_rd;
    t_dv n_rd;
    t_dv r_pp;
    t_dv n_pp;
    logic [2:0][W-1:0] r_rd_mag;

    always_comb begin
        n_rd      = '0;
        n_rd.cmd  = r_sq[RT-1].cmd;
        n_rd.res  = r_sq[RT-1].res;
        n_rd.neg  = r_sq[RT-1].neg;
        n_rd.zero = r_sq[RT-1].zero;
        // round to nearest: bump when the remainder exceeds the root
        n_rd.len  = LW'(r_sq[RT-1].root)
                  + LW'(r_sq[RT-1].rem > SQ'(r_sq[RT-1].root));
    end

    always_comb begin
        n_pp = r_rd;
        for (int i = 0; i < 3; i++) begin
            n_pp.rem[i] = (NW'(r_rd_mag[i]) << FRAC_BITS) + NW'(r_rd.len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd     <= n_rd;
            r_rd_mag <= r_sq[RT-1].mag;
            r_pp     <= n_pp;
        end
    end

    // ---------------------------------------------------------------- divider
    // Three restoring dividers, one quotient bit per stage.
    t_dv r_dv [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        t_dv           d_in;
        t_dv           d_nx;
        logic [DW-1:0] dv;

        if (j == 0) begin : g_first
            assign d_in = r_pp;
        end else begin : g_next
            assign d_in = r_dv[j-1];
        end

        always_comb begin
            dv   = DW'(d_in.len) << K;
            d_nx = d_in;
            for (int i = 0; i < 3; i++) begin
                if (DW'(d_in.rem[i]) >= dv) begin
                    d_nx.rem[i]    = NW'(DW'(d_in.rem[i]) - dv);
                    d_nx.quo[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[j] <= d_nx;
            end
        end
    end

    // ---------------------------------------------------------------- assemble
    // Each quotient is at most about one, so normalize never clips.
    always_comb begin
        t_dv        d;
        logic [W:0] sr;
        d     = r_dv[QB-1];
        sr    = sat_fn(XW'(d.len));
        n_out = '0;
        n_out.r_x      = d.res.vec[0];
        n_out.r_y      = d.res.vec[1];
        n_out.r_z      = d.res.vec[2];
        n_out.r_scalar = d.res.sc;
        n_out.saturated = d.res.clip;
        case (d.cmd) inside
            CMD_LENGTH: begin
                n_out.r_scalar  = sr[W-1:0];
                n_out.saturated = sr[W];
            end
            CMD_NORM, CMD_UNIT: begin
                if (d.zero) begin
                    n_out.zero_length = 1'b1;
                end else begin
                    n_out.r_x = d.neg[0] ? -W'(d.quo[0]) : W'(d.quo[0]);
                    n_out.r_y = d.neg[1] ? -W'(d.quo[1]) : W'(d.quo[1]);
                    n_out.r_z = d.neg[2] ? -W'(d.quo[2]) : W'(d.quo[2]);
                end
            end
            default: begin
                n_out.zero_length = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/v3alu_chk.sv
// Port-level checker for vec3_alu_core, attached by bind.
// Depends on v3alu_pkg for the payload types.
`default_nettype none

module v3alu_chk (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             o_in_ready,
    input wire             o_out_valid,
    input wire             i_out_ready,
    input v3alu_pkg::t_out o_out_data
);
    import v3alu_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output data changed while stalled");

    // back pressure only comes from results waiting at the output
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_length |->
            o_out_data.r_x == '0 && o_out_data.r_y == '0 &&
            o_out_data.r_z == '0 && o_out_data.r_scalar == '0)
        else $error("zero-length result carries nonzero values");

endmodule

bind vec3_alu_core v3alu_chk u_v3alu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for vec3_alu_core: directed table, then random traffic.
// Depends on rtl/v3alu_pkg.sv and rtl/vec3_alu_core.sv; forms every expected result itself.
`default_nettype none

module testbench;
    import v3alu_pkg::*;

    localparam int FRAC      = 16;
    localparam int HOLD_LEN  = 400;   // long receiver hold, fills the pipe
    localparam int WDOG_MAX  = 3000;  // cycles without any transfer
    localparam int TAIL_WAIT = 100;   // wait after the drain, beyond the pipeline latency
    localparam int PHASE_LEN = 330;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SPARE    = 4'd15;
    localparam logic signed [WORD_W-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [WORD_W-1:0] WMAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WMIN = 32'sh8000_0000;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_in  d;
        bit   known;
        t_out want;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    t_in   in_data;
    logic  in_ready;
    logic  out_valid;
    logic  out_ready;
    t_out  out_data;

    t_out  results_due[$];
    t_row  dir_tab[$];
    int    err_cnt   = 0;
    int    snd_pct   = 0;
    int    rcv_pct   = 0;
    bit    hold_req  = 0;
    int    hold_cnt  = 0;
    int    quiet_cyc = 0;

    vec3_alu_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor: fixed-point vector math at 128-bit width
    // ---------------------------------------------------------------
    function automatic logic signed [WORD_W-1:0] clip32(t_wide v, inout bit cl);
        if (v > t_wide'(64'sd2147483647)) begin
            cl = 1'b1;
            return WMAX;
        end
        if (v < -t_wide'(64'sd2147483648)) begin
            cl = 1'b1;
            return WMIN;
        end
        return v[WORD_W-1:0];
    endfunction

    // drop FRAC bits, ties toward plus infinity
    function automatic t_wide round_frac(t_wide v);
        return (v + (t_wide'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // square root rounded to nearest
    function automatic logic [63:0] root_near(logic [63:0] s);
        logic [63:0] x, res, bt;
        x   = s;
        res = 0;
        bt  = 64'h4000_0000_0000_0000;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        if (s - res * res > res) res = res + 1;
        return res;
    endfunction

    function automatic logic [63:0] sq_sum(t_wide x, t_wide y, t_wide z);
        t_wide s;
        s = x * x + y * y + z * z;
        return s[63:0];
    endfunction

    function automatic void make_unit(input t_wide x, input t_wide y, input t_wide z,
                                      output logic signed [WORD_W-1:0] rx,
                                      output logic signed [WORD_W-1:0] ry,
                                      output logic signed [WORD_W-1:0] rz,
                                      inout bit zl, inout bit cl);
        logic [63:0] s;
        t_wide len, mag, q;
        t_wide comp [3];
        logic signed [WORD_W-1:0] uvec [3];
        s = sq_sum(x, y, z);
        rx = 0; ry = 0; rz = 0;
        if (s == 0) begin
            zl = 1'b1;
            return;
        end
        len  = t_wide'(root_near(s));
        comp = '{x, y, z};
        for (int i = 0; i < 3; i++) begin
            mag     = (comp[i] < 0 ? -comp[i] : comp[i]) <<< FRAC;
            q       = (mag + (len >>> 1)) / len;
            uvec[i] = clip32(comp[i] < 0 ? -q : q, cl);
        end
        rx = uvec[0]; ry = uvec[1]; rz = uvec[2];
    endfunction

    function automatic t_out alu_eval(t_in d);
        t_wide ax, ay, az, bx, by, bz, sc;
        logic signed [WORD_W-1:0] cx, cy, cz;
        t_out o;
        bit zl, cl;
        ax = d.a_x; ay = d.a_y; az = d.a_z;
        bx = d.b_x; by = d.b_y; bz = d.b_z;
        sc = d.scale;
        o  = '0;
        zl = 0; cl = 0;
        case (d.cmd)
            CMD_ADD: begin
                o.r_x = clip32(ax + bx, cl);
                o.r_y = clip32(ay + by, cl);
                o.r_z = clip32(az + bz, cl);
            end
            CMD_SUB: begin
                o.r_x = clip32(ax - bx, cl);
                o.r_y = clip32(ay - by, cl);
                o.r_z = clip32(az - bz, cl);
            end
            CMD_SCALE: begin
                o.r_x = clip32(round_frac(ax * sc), cl);
                o.r_y = clip32(round_frac(ay * sc), cl);
                o.r_z = clip32(round_frac(az * sc), cl);
            end
            CMD_DOT:    o.r_scalar = clip32(round_frac(ax * bx + ay * by + az * bz), cl);
            CMD_SQLEN:  o.r_scalar = clip32(round_frac(ax * ax + ay * ay + az * az), cl);
            CMD_LENGTH: o.r_scalar = clip32(t_wide'(root_near(sq_sum(ax, ay, az))), cl);
            CMD_NORM:   make_unit(ax, ay, az, o.r_x, o.r_y, o.r_z, zl, cl);
            CMD_CROSS, CMD_UNIT: begin
                cx = clip32(round_frac(ay * bz - by * az), cl);
                cy = clip32(round_frac(az * bx - bz * ax), cl);
                cz = clip32(round_frac(ax * by - bx * ay), cl);
                if (d.cmd == CMD_CROSS) begin
                    o.r_x = cx; o.r_y = cy; o.r_z = cz;
                end else begin
                    make_unit(cx, cy, cz, o.r_x, o.r_y, o.r_z, zl, cl);
                end
            end
            default: ;  // spare codes give all zeros
        endcase
        o.zero_length = zl;
        o.saturated   = cl;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_in mk(logic [CMD_W-1:0] c,
                               logic signed [WORD_W-1:0] ax, ay, az, bx, by, bz, s);
        t_in d;
        d = '{cmd: c, a_x: ax, a_y: ay, a_z: az, b_x: bx, b_y: by, b_z: bz, scale: s};
        return d;
    endfunction

    function automatic t_out res(logic signed [WORD_W-1:0] x, y, z, s, bit zl, bit cl);
        t_out o;
        o = '{r_x: x, r_y: y, r_z: z, r_scalar: s, zero_length: zl, saturated: cl};
        return o;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            7:       return WMAX;
            8:       return WMIN;
            9:       return 0;
            4, 5, 6: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in d;
        d.cmd = ($urandom_range(0, 9) == 0) ?
                4'($urandom_range(CMD_SPARE_LO, CMD_SPARE)) :
                4'($urandom_range(CMD_ADD, CMD_UNIT));
        d.a_x = rand_word(); d.a_y = rand_word(); d.a_z = rand_word();
        d.b_x = rand_word(); d.b_y = rand_word(); d.b_z = rand_word();
        d.scale = rand_word();
        // parallel operands push unit normal into its zero-vector case
        if (d.cmd == CMD_UNIT && $urandom_range(0, 9) == 0) begin
            d.b_x = d.a_x; d.b_y = d.a_y; d.b_z = d.a_z;
        end
        return d;
    endfunction

    // Offer one item, hold it until the transfer, then maybe idle.
    task automatic send_item(t_in d, bit known, t_out want);
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        results_due.push_back(known ? want : alu_eval(d));
        while ($urandom_range(0, 99) < snd_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: check each transfer, then pick next ready
    // ---------------------------------------------------------------
    initial begin
        t_out w;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid === 1'b1 && out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result with nothing expected: %h", out_data);
                    err_cnt++;
                end else begin
                    w = results_due.pop_front();
                    if (out_data.r_x !== w.r_x) begin
                        $error("r_x exp %h got %h", w.r_x, out_data.r_x); err_cnt++;
                    end
                    if (out_data.r_y !== w.r_y) begin
                        $error("r_y exp %h got %h", w.r_y, out_data.r_y); err_cnt++;
                    end
                    if (out_data.r_z !== w.r_z) begin
                        $error("r_z exp %h got %h", w.r_z, out_data.r_z); err_cnt++;
                    end
                    if (out_data.r_scalar !== w.r_scalar) begin
                        $error("r_scalar exp %h got %h", w.r_scalar, out_data.r_scalar);
                        err_cnt++;
                    end
                    if (out_data.zero_length !== w.zero_length) begin
                        $error("zero_length exp %b got %b", w.zero_length,
                               out_data.zero_length);
                        err_cnt++;
                    end
                    if (out_data.saturated !== w.saturated) begin
                        $error("saturated exp %b got %b", w.saturated, out_data.saturated);
                        err_cnt++;
                    end
                end
            end
            // long hold: stall the output while the sender keeps pushing
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = HOLD_LEN;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rcv_pct);
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    initial begin
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                quiet_cyc = 0;
            else
                quiet_cyc++;
            if (quiet_cyc >= WDOG_MAX) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        in_valid = 1'b0;
        in_data  = '0;
        i_rst_n  = 1'b0;

        // hand-checked rows carry their result, the rest go through the predictor
        dir_tab.push_back('{mk(CMD_ADD, 0, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(CMD_ADD, WMAX, 0, 0, ONE, 0, 0, 0), 1,
                            res(WMAX, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{mk(CMD_SUB, WMIN, 0, 0, ONE, 0, 0, 0), 1,
                            res(WMIN, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{mk(CMD_NORM, 0, 0, 0, ONE, ONE, ONE, ONE), 1,
                            res(0, 0, 0, 0, 1, 0)});
        dir_tab.push_back('{mk(CMD_NORM, ONE, 0, 0, 0, 0, 0, 0), 1,
                            res(ONE, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(CMD_LENGTH, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0), 1,
                            res(0, 0, 0, 5 * ONE, 0, 0)});
        dir_tab.push_back('{mk(CMD_CROSS, 0, 0, 0, WMAX, WMIN, WMAX, 0), 1,
                            res(0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(CMD_SPARE, WMAX, WMIN, ONE, WMAX, WMIN, ONE, WMAX), 1,
                            res(0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(CMD_SPARE_LO, -1, -1, -1, -1, -1, -1, -1), 1,
                            res(0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(CMD_ADD, WMIN, WMIN, WMAX, WMIN, -1, WMAX, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_SUB, WMAX, WMIN, 0, WMIN, WMAX, -1, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_SCALE, WMAX, WMIN, ONE, 0, 0, 0, WMIN), 0, '0});
        dir_tab.push_back('{mk(CMD_SCALE, ONE, -ONE, 3, 0, 0, 0, 32'sh0000_8000), 0, '0});
        dir_tab.push_back('{mk(CMD_DOT, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_DOT, WMAX, ONE, -ONE, WMIN, ONE, ONE, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_CROSS, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_CROSS, ONE, 0, 0, 0, ONE, 0, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_SQLEN, WMIN, WMIN, WMIN, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_SQLEN, 1, -1, 32'sh0000_00ff, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_LENGTH, WMIN, WMIN, WMIN, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_NORM, WMIN, WMAX, 1, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_NORM, 1, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_UNIT, ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0),
                            0, '0});
        dir_tab.push_back('{mk(CMD_UNIT, WMAX, WMIN, 0, WMIN, 0, WMAX, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_UNIT, ONE, 0, 0, 0, ONE, 0, 0), 0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_item(dir_tab[i].d, dir_tab[i].known, dir_tab[i].want);

        // phase 0: light sender gaps, heavy receiver stalls
        snd_pct = 19; rcv_pct = 85;
        repeat (PHASE_LEN) send_item(rand_item(), 0, '0);

        // pause the sender until the pipe is empty
        drain();

        // phase 1: the other way round
        snd_pct = 85; rcv_pct = 19;
        repeat (PHASE_LEN) send_item(rand_item(), 0, '0);

        // phase 2: full rate, with one long output hold up front
        snd_pct = 0; rcv_pct = 0;
        hold_req = 1;
        repeat (PHASE_LEN) send_item(rand_item(), 0, '0);

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
